/* hdl/lcdnw_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lcdnw_pkg
// Shared types, codes and tables for the 4-bit character LCD nibble writer.
// -----------------------------------------------------------------------------
package lcdnw_pkg;

  // Field widths
  localparam int unsigned OpW      = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ColW     = 6;
  localparam int unsigned RowW     = 3;
  localparam int unsigned RegW     = 22;
  localparam int unsigned HoldW    = 23;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned InUserW  = 4;
  localparam int unsigned OutDataW = 32;

  // Job queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Command constants
  localparam logic [RowW-1:0]  RowMax     = 3'd7;
  localparam logic [ByteW-1:0] NewlineChr = 8'h0A;
  localparam logic [ByteW-1:0] SetAddrCmd = 8'h80;
  localparam logic [ByteW-1:0] ClearCmd   = 8'h01;
  localparam logic [2:0]       InitLast   = 3'd5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPulse = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgExec  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgClear = 2'd2;

  // Configuration reset values
  localparam logic [RegW-1:0] PulseRst = 22'd100;
  localparam logic [RegW-1:0] ExecRst  = 22'd5000;
  localparam logic [RegW-1:0] ClearRst = 22'd300000;

  typedef enum logic [OpW-1:0] {
    OP_TEXT  = 3'd0,
    OP_CMD   = 3'd1,
    OP_MOVE  = 3'd2,
    OP_CLEAR = 3'd3,
    OP_INIT  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    JOB_BYTE  = 2'd0,
    JOB_CLEAR = 2'd1,
    JOB_INIT  = 2'd2
  } job_kind_e;

  typedef struct packed {
    job_kind_e        kind;
    logic             rs;
    logic [ByteW-1:0] cmd_byte;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_head_t;

  // DDRAM offset of each display row; rows past 3 start at 0
  function automatic logic [6:0] row_offset(input logic [RowW-1:0] row);
    logic [6:0] off;
    unique case (row)
      3'd1:    off = 7'h40;
      3'd2:    off = 7'h14;
      3'd3:    off = 7'h54;
      default: off = 7'h00;
    endcase
    return off;
  endfunction

  // Power-up command sequence, ending with clear display
  function automatic logic [ByteW-1:0] init_cmd(input logic [2:0] idx);
    logic [ByteW-1:0] cmd;
    unique case (idx)
      3'd0:    cmd = 8'h33;
      3'd1:    cmd = 8'h32;
      3'd2:    cmd = 8'h0C;
      3'd3:    cmd = 8'h28;
      3'd4:    cmd = 8'h06;
      default: cmd = ClearCmd;
    endcase
    return cmd;
  endfunction

endpackage

/* hdl/lcdnw_front.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lcdnw_front
// Accepts requests, tracks the text row and turns each request into a job.
// -----------------------------------------------------------------------------
module lcdnw_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [lcdnw_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic [lcdnw_pkg::InUserW-1:0]  s_axis_tuser,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output lcdnw_pkg::job_t                q_job_o
);
  import lcdnw_pkg::*;

  logic [ByteW-1:0] byte_value;
  logic [ColW-1:0]  column;
  logic [RowW-1:0]  cursor_row;
  logic [OpW-1:0]   op_bits;
  logic             first_of_string;
  logic             accept;
  logic [RowW-1:0]  text_row_q, text_row_d;
  logic [RowW-1:0]  row_base, row_next;
  logic [6:0]       move_addr;
  logic             job_ok;

  // Unpack the transaction
  assign byte_value      = s_axis_tdata[7:0];
  assign column          = s_axis_tdata[13:8];
  assign cursor_row      = s_axis_tdata[16:14];
  assign op_bits         = s_axis_tuser[2:0];
  assign first_of_string = s_axis_tuser[3];

  assign s_axis_tready = !q_full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Row bookkeeping for newlines
  assign row_base  = first_of_string ? '0 : text_row_q;
  assign row_next  = (row_base < RowMax) ? row_base + 3'd1 : row_base;
  assign move_addr = {1'b0, column} + row_offset(cursor_row);

  // Classify the request
  always_comb begin
    job_ok           = 1'b1;
    text_row_d       = text_row_q;
    q_job_o.kind     = JOB_BYTE;
    q_job_o.rs       = 1'b1;
    q_job_o.cmd_byte = byte_value;
    unique case (op_e'(op_bits))
      OP_TEXT: begin
        if (byte_value == NewlineChr) begin
          text_row_d       = row_next;
          q_job_o.cmd_byte = SetAddrCmd | {1'b0, row_offset(row_next)};
        end else begin
          text_row_d = row_base;
          q_job_o.rs = 1'b0;
        end
      end
      OP_CMD: ;
      OP_MOVE: q_job_o.cmd_byte = SetAddrCmd | {1'b0, move_addr};
      OP_CLEAR: begin
        q_job_o.kind     = JOB_CLEAR;
        q_job_o.cmd_byte = ClearCmd;
      end
      OP_INIT: q_job_o.kind = JOB_INIT;
      default: job_ok = 1'b0;
    endcase
  end

  assign q_push_o = accept && job_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_row_q <= '0;
    end else if (accept) begin
      text_row_q <= text_row_d;
    end
  end

endmodule

/* hdl/lcdnw_fifo.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lcdnw_fifo
// Short job queue that decouples request intake from segment generation.
// -----------------------------------------------------------------------------
module lcdnw_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lcdnw_pkg::job_t      job_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output lcdnw_pkg::job_head_t head_o
);
  import lcdnw_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;

  assign full_o       = (count_q == QCntW'(QDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.job   = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* hdl/lcdnw_back.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lcdnw_back
// Steps the head job's nibbles and enable phases, one segment a cycle unless held.
// -----------------------------------------------------------------------------
module lcdnw_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lcdnw_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [lcdnw_pkg::RegW-1:0]           cfg_data_i,
  input  lcdnw_pkg::job_head_t                 head_i,
  output logic                                 pop_o,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [lcdnw_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast
);
  import lcdnw_pkg::*;

  logic [RegW-1:0]  pulse_q, exec_q, clear_q;
  logic [2:0]       cmd_idx_q;
  logic             nib_sel_q;
  logic [1:0]       phase_q;
  logic             extra_q;
  logic             step;
  logic [ByteW-1:0] cur_byte;
  logic [3:0]       nib;
  logic             seg_en;
  logic [HoldW-1:0] seg_hold;
  logic             seg_last;
  logic             nibble_done;

  logic             out_valid_q;
  logic             out_rs_q;
  logic [3:0]       out_pins_q;
  logic             out_en_q;
  logic [HoldW-1:0] out_hold_q;
  logic             out_last_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_q <= PulseRst;
      exec_q  <= ExecRst;
      clear_q <= ClearRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPulse: pulse_q <= cfg_data_i;
        CfgExec:  exec_q  <= cfg_data_i;
        CfgClear: clear_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Segment for the current position in the head job
  assign step        = head_i.valid && (!out_valid_q || m_axis_tready);
  assign cur_byte    = (head_i.job.kind == JOB_INIT) ? init_cmd(cmd_idx_q)
                                                     : head_i.job.cmd_byte;
  // the clear wait segment repeats the low nibble of the clear command
  assign nib         = (nib_sel_q || extra_q) ? cur_byte[3:0] : cur_byte[7:4];
  assign nibble_done = (phase_q == 2'd2) && nib_sel_q;

  always_comb begin
    seg_en   = extra_q || (phase_q != 2'd1);
    seg_hold = {1'b0, pulse_q};
    if (extra_q) begin
      seg_hold = {1'b0, clear_q};
    end else if (phase_q == 2'd2) begin
      seg_hold = {1'b0, pulse_q} + {1'b0, exec_q};
    end
    seg_last = extra_q || (nibble_done && (head_i.job.kind == JOB_BYTE));
  end

  assign pop_o = step && seg_last;

  // Sequencer counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_idx_q <= '0;
      nib_sel_q <= 1'b0;
      phase_q   <= '0;
      extra_q   <= 1'b0;
    end else if (step) begin
      if (seg_last) begin
        cmd_idx_q <= '0;
        nib_sel_q <= 1'b0;
        phase_q   <= '0;
        extra_q   <= 1'b0;
      end else if (phase_q != 2'd2) begin
        phase_q <= phase_q + 2'd1;
      end else begin
        phase_q   <= '0;
        nib_sel_q <= !nib_sel_q;
        if (nib_sel_q) begin
          if (head_i.job.kind == JOB_CLEAR || cmd_idx_q == InitLast) begin
            extra_q <= 1'b1;
          end else begin
            cmd_idx_q <= cmd_idx_q + 3'd1;
          end
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_rs_q   <= head_i.job.rs;
      out_pins_q <= ~nib;
      out_en_q   <= seg_en;
      out_hold_q <= seg_hold;
      out_last_q <= seg_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_hold_q, out_en_q, out_pins_q};
  assign m_axis_tuser  = out_rs_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* hdl/char_lcd_nibble_writer_unit.sv */
`timescale 1ns / 1ps
// A request's first segment appears after the job queue and the output register.
// Throughput: one segment per cycle from the segment sequencer unless stalled;
//   a two-entry job queue lets intake run ahead.
// Reset (rst_ni low, asynchronous): queue empty, text row 0, timing registers
//   back to 100 / 5000 / 300000 ticks.
// -----------------------------------------------------------------------------
// char_lcd_nibble_writer_unit
// Turns LCD requests into timed pin segments for a 4-bit character LCD bus.
// -----------------------------------------------------------------------------
module char_lcd_nibble_writer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [lcdnw_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [lcdnw_pkg::RegW-1:0]          cfg_data_i,
  // request stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] byte_value, [13:8] column, [16:14] cursor_row, [23:17] zero
  input  logic [lcdnw_pkg::InDataW-1:0]       s_axis_tdata,
  // [2:0] operation, [3] first_of_string
  input  logic [lcdnw_pkg::InUserW-1:0]       s_axis_tuser,
  // segment stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [3:0] data_pins, [4] enable_pin, [27:5] hold_ticks, [31:28] zero
  output logic [lcdnw_pkg::OutDataW-1:0]      m_axis_tdata,
  // [0] rs_pin
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast
);
  import lcdnw_pkg::*;

  logic      q_full;
  logic      q_push;
  logic      q_pop;
  job_t      q_job;
  job_head_t q_head;

  lcdnw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_job_o       (q_job)
  );

  lcdnw_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (q_job),
    .full_o (q_full),
    .pop_i  (q_pop),
    .head_o (q_head)
  );

  lcdnw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .head_i        (q_head),
    .pop_o         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* hdl/lcdnw_checker.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lcdnw_checker
// Port-level checks on the segment stream of the nibble writer.
// -----------------------------------------------------------------------------
module lcdnw_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [lcdnw_pkg::OutDataW-1:0]     m_axis_tdata,
  input logic                               m_axis_tuser,
  input logic                               m_axis_tlast
);
  import lcdnw_pkg::*;

  // A pending segment stays offered until taken
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("segment withdrawn before transaction");

  // Nothing is offered right out of reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("segment offered during reset");

  // A run always ends on an enable-high phase
  a_last_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[4])
    else $error("run ends with enable low");

  // Enable-low phase is the middle of a nibble: next segment keeps rs and pins
  a_low_then_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tdata[4] && m_axis_tvalid
    |=> !m_axis_tvalid || (m_axis_tuser == $past(m_axis_tuser)
         && m_axis_tdata[3:0] == $past(m_axis_tdata[3:0])))
    else $error("pins changed after enable-low phase");

  // Padding bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[31:28] == 4'b0)
    else $error("padding bits set");

endmodule

bind char_lcd_nibble_writer_unit lcdnw_checker u_lcdnw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
